// ===== rtl/core/tslp_pkg.sv =====
// Shared types, codes and default constants of the two-axis slew limiter.
`timescale 1ns / 1ps

package tslp_pkg;

    // Default geometry
    localparam int ANGLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 4;

    // Fixed field widths
    localparam int OP_BITS   = 4;
    localparam int STEP_BITS = 11;
    localparam int TICK_BITS = 16;
    localparam int ADDR_BITS = 3;

    // Reset values in whole degrees or ticks
    localparam int YAW_LIMIT_DEG   = 20;
    localparam int PITCH_LIMIT_DEG = 12;
    localparam int INTERVAL_RST    = 30;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK      = 4'd0,
        OP_SET_YAW   = 4'd1,
        OP_SET_PITCH = 4'd2,
        OP_SET_POSE  = 4'd3,
        OP_LEFT      = 4'd4,
        OP_RIGHT     = 4'd5,
        OP_UP        = 4'd6,
        OP_DOWN      = 4'd7,
        OP_CENTER    = 4'd8
    } t_op;

    typedef enum logic [ADDR_BITS-1:0] {
        CFG_YAW_MIN     = 3'd0,
        CFG_YAW_MAX     = 3'd1,
        CFG_PITCH_MIN   = 3'd2,
        CFG_PITCH_MAX   = 3'd3,
        CFG_STEP_SIZE   = 3'd4,
        CFG_INTERVAL    = 3'd5,
        CFG_YAW_NUDGE   = 3'd6,
        CFG_PITCH_NUDGE = 3'd7
    } t_cfg_addr;

    // Per-axis action for one accepted request
    typedef struct packed {
        logic load;   // take the requested angle as target
        logic dec;    // target minus nudge
        logic inc;    // target plus nudge
        logic zero;   // target to zero
        logic slew;   // move current angle toward target
    } t_axis_cmd;

endpackage

// ===== rtl/core/tslp_ifs.sv =====
// Valid/ready channel interfaces: command input, result output, register write.
`timescale 1ns / 1ps

interface tslp_cmd_if
    import tslp_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [OP_BITS-1:0]           operation;
    logic signed [ANGLE_BITS-1:0] yaw_value;
    logic signed [ANGLE_BITS-1:0] pitch_value;

    modport source (output valid, operation, yaw_value, pitch_value, input ready);
    modport sink   (input valid, operation, yaw_value, pitch_value, output ready);
endinterface

interface tslp_res_if
    import tslp_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] yaw_now;
    logic signed [ANGLE_BITS-1:0] pitch_now;
    logic signed [ANGLE_BITS-1:0] yaw_goal;
    logic signed [ANGLE_BITS-1:0] pitch_goal;
    logic                         moving;
    logic                         yaw_write;
    logic                         pitch_write;

    modport source (output valid, yaw_now, pitch_now, yaw_goal, pitch_goal, moving,
                    yaw_write, pitch_write, input ready);
    modport sink   (input valid, yaw_now, pitch_now, yaw_goal, pitch_goal, moving,
                    yaw_write, pitch_write, output ready);
endinterface

interface tslp_cfg_if
    import tslp_pkg::*;
#(
    parameter int DATA_BITS = TICK_BITS
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/tslp_axis.sv =====
// One axis: target update with clamping, and slew of the current angle.
`timescale 1ns / 1ps

module tslp_axis
    import tslp_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  t_axis_cmd                    i_cmd,
    input  logic signed [ANGLE_BITS-1:0] i_value,
    input  logic signed [ANGLE_BITS-1:0] i_min,
    input  logic signed [ANGLE_BITS-1:0] i_max,
    input  logic [STEP_BITS-1:0]         i_nudge,
    input  logic [STEP_BITS-1:0]         i_step,
    output logic signed [ANGLE_BITS-1:0] o_pos_nxt,
    output logic signed [ANGLE_BITS-1:0] o_goal_nxt,
    output logic                         o_write
);

    // wide enough for angle +/- 11-bit amount without wrap
    localparam int WB = ((ANGLE_BITS > STEP_BITS) ? ANGLE_BITS : STEP_BITS) + 2;

    logic signed [ANGLE_BITS-1:0] r_pos, r_goal;
    logic signed [ANGLE_BITS-1:0] n_pos, n_goal;

    logic signed [WB-1:0] w_pos, w_goal, w_min, w_max, w_nudge, w_step, w_value;
    logic signed [WB-1:0] w_cand, w_clamped, w_up, w_dn, w_slewed;

    always_comb begin
        w_pos   = {{(WB-ANGLE_BITS){r_pos[ANGLE_BITS-1]}}, r_pos};
        w_goal  = {{(WB-ANGLE_BITS){r_goal[ANGLE_BITS-1]}}, r_goal};
        w_min   = {{(WB-ANGLE_BITS){i_min[ANGLE_BITS-1]}}, i_min};
        w_max   = {{(WB-ANGLE_BITS){i_max[ANGLE_BITS-1]}}, i_max};
        w_value = {{(WB-ANGLE_BITS){i_value[ANGLE_BITS-1]}}, i_value};
        w_nudge = {{(WB-STEP_BITS){1'b0}}, i_nudge};
        w_step  = {{(WB-STEP_BITS){1'b0}}, i_step};

        if (i_cmd.load) begin
            w_cand = w_value;
        end else if (i_cmd.dec) begin
            w_cand = w_goal - w_nudge;
        end else if (i_cmd.inc) begin
            w_cand = w_goal + w_nudge;
        end else begin
            w_cand = '0;
        end

        // below min wins over above max, also with crossed limits
        if (w_cand < w_min) begin
            w_clamped = w_min;
        end else if (w_cand > w_max) begin
            w_clamped = w_max;
        end else begin
            w_clamped = w_cand;
        end

        w_up = w_pos + w_step;
        w_dn = w_pos - w_step;
        if (w_pos < w_goal) begin
            w_slewed = (w_up > w_goal) ? w_goal : w_up;
        end else if (w_pos > w_goal) begin
            w_slewed = (w_dn < w_goal) ? w_goal : w_dn;
        end else begin
            w_slewed = w_pos;
        end

        if (i_cmd.load || i_cmd.dec || i_cmd.inc || i_cmd.zero) begin
            n_goal = w_clamped[ANGLE_BITS-1:0];
        end else begin
            n_goal = r_goal;
        end

        n_pos = i_cmd.slew ? w_slewed[ANGLE_BITS-1:0] : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_goal <= '0;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_goal <= n_goal;
        end
    end

    assign o_pos_nxt  = n_pos;
    assign o_goal_nxt = n_goal;
    assign o_write    = i_cmd.slew && (n_pos != r_pos);

endmodule

// ===== rtl/core/two_axis_slew_limited_positioner_top.sv =====
// Top level of the two-axis slew-limited servo positioner.
`timescale 1ns / 1ps

// Usage
//   i_cmd  : request channel. operation selects a millisecond tick, an absolute
//            yaw, pitch or pose target, a nudge left/right/up/down, or center.
//            yaw_value / pitch_value carry absolute angles (1/16 degree default).
//   o_res  : one result per request: current and target angles after the
//            request, the moving flag and one servo-write strobe per axis.
//   i_cfg  : register writes (limits, step size, update interval, nudges).
//            Always ready; write only while no request is in flight.
// Latency : a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while ready. The state update (clamp, nudge
//   add, slew add and compare) is a single combinational pass into the state
//   and result registers, so back-to-back requests see each other's effect.
// Stall   : the result register holds until taken; i_cmd.ready stays high
//   while the result register is empty or being drained the same cycle.
// Reset   : synchronous, active low. Angles, targets and the tick counter
//   clear to zero, registers load their defaults (+/-20 and +/-12 degree
//   limits, 1 degree step and nudges, 30 ticks per update).

module two_axis_slew_limited_positioner_top
    import tslp_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tslp_cmd_if.sink    i_cmd,
    tslp_res_if.source  o_res,
    tslp_cfg_if.sink    i_cfg
);

    localparam int ONE_DEG = 1 << FRAC_BITS;

    localparam logic [ANGLE_BITS-1:0] YAW_MIN_RST   = ANGLE_BITS'(-(YAW_LIMIT_DEG * ONE_DEG));
    localparam logic [ANGLE_BITS-1:0] YAW_MAX_RST   = ANGLE_BITS'(YAW_LIMIT_DEG * ONE_DEG);
    localparam logic [ANGLE_BITS-1:0] PITCH_MIN_RST = ANGLE_BITS'(-(PITCH_LIMIT_DEG * ONE_DEG));
    localparam logic [ANGLE_BITS-1:0] PITCH_MAX_RST = ANGLE_BITS'(PITCH_LIMIT_DEG * ONE_DEG);
    localparam logic [STEP_BITS-1:0]  STEP_RST      = STEP_BITS'(ONE_DEG);
    localparam logic [TICK_BITS-1:0]  INTERVAL_DEF  = TICK_BITS'(INTERVAL_RST);

    // ---------------- configuration registers ----------------
    logic signed [ANGLE_BITS-1:0] r_yaw_min, r_yaw_max, r_pitch_min, r_pitch_max;
    logic [STEP_BITS-1:0]         r_step, r_yaw_nudge, r_pitch_nudge;
    logic [TICK_BITS-1:0]         r_interval;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_min     <= YAW_MIN_RST;
            r_yaw_max     <= YAW_MAX_RST;
            r_pitch_min   <= PITCH_MIN_RST;
            r_pitch_max   <= PITCH_MAX_RST;
            r_step        <= STEP_RST;
            r_interval    <= INTERVAL_DEF;
            r_yaw_nudge   <= STEP_RST;
            r_pitch_nudge <= STEP_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_addr'(i_cfg.addr))
                CFG_YAW_MIN:     r_yaw_min     <= i_cfg.data[ANGLE_BITS-1:0];
                CFG_YAW_MAX:     r_yaw_max     <= i_cfg.data[ANGLE_BITS-1:0];
                CFG_PITCH_MIN:   r_pitch_min   <= i_cfg.data[ANGLE_BITS-1:0];
                CFG_PITCH_MAX:   r_pitch_max   <= i_cfg.data[ANGLE_BITS-1:0];
                CFG_STEP_SIZE:   r_step        <= i_cfg.data[STEP_BITS-1:0];
                CFG_INTERVAL:    r_interval    <= i_cfg.data[TICK_BITS-1:0];
                CFG_YAW_NUDGE:   r_yaw_nudge   <= i_cfg.data[STEP_BITS-1:0];
                CFG_PITCH_NUDGE: r_pitch_nudge <= i_cfg.data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- request decode ----------------
    logic      w_accept;
    logic      w_update;
    logic [TICK_BITS:0] w_ticks_inc;
    t_axis_cmd w_yaw_cmd, w_pitch_cmd;

    logic [TICK_BITS-1:0] r_ticks, n_ticks;

    // accept while the result slot is free or drains this cycle
    assign i_cmd.ready = !o_res.valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // interval of zero behaves like one: every tick updates
    assign w_ticks_inc = {1'b0, r_ticks} + {{TICK_BITS{1'b0}}, 1'b1};

    always_comb begin
        w_yaw_cmd   = '0;
        w_pitch_cmd = '0;
        w_update    = 1'b0;
        n_ticks     = r_ticks;
        case (t_op'(i_cmd.operation))
            OP_TICK: begin
                if (w_ticks_inc >= {1'b0, r_interval}) begin
                    w_update         = 1'b1;
                    n_ticks          = '0;
                    w_yaw_cmd.slew   = 1'b1;
                    w_pitch_cmd.slew = 1'b1;
                end else begin
                    n_ticks = w_ticks_inc[TICK_BITS-1:0];
                end
            end
            OP_SET_YAW:   w_yaw_cmd.load = 1'b1;
            OP_SET_PITCH: w_pitch_cmd.load = 1'b1;
            OP_SET_POSE: begin
                w_yaw_cmd.load   = 1'b1;
                w_pitch_cmd.load = 1'b1;
            end
            OP_LEFT:  w_yaw_cmd.dec = 1'b1;
            OP_RIGHT: w_yaw_cmd.inc = 1'b1;
            OP_UP:    w_pitch_cmd.dec = 1'b1;
            OP_DOWN:  w_pitch_cmd.inc = 1'b1;
            OP_CENTER: begin
                w_yaw_cmd.zero   = 1'b1;
                w_pitch_cmd.zero = 1'b1;
            end
            default: ;  // unused codes leave the state alone
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
        end else if (w_accept) begin
            r_ticks <= n_ticks;
        end
    end

    // ---------------- axes ----------------
    logic signed [ANGLE_BITS-1:0] w_yaw_pos, w_yaw_goal, w_pitch_pos, w_pitch_goal;
    logic                         w_yaw_write, w_pitch_write;

    tslp_axis #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_accept),
        .i_cmd      (w_yaw_cmd),
        .i_value    (i_cmd.yaw_value),
        .i_min      (r_yaw_min),
        .i_max      (r_yaw_max),
        .i_nudge    (r_yaw_nudge),
        .i_step     (r_step),
        .o_pos_nxt  (w_yaw_pos),
        .o_goal_nxt (w_yaw_goal),
        .o_write    (w_yaw_write)
    );

    tslp_axis #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_accept),
        .i_cmd      (w_pitch_cmd),
        .i_value    (i_cmd.pitch_value),
        .i_min      (r_pitch_min),
        .i_max      (r_pitch_max),
        .i_nudge    (r_pitch_nudge),
        .i_step     (r_step),
        .o_pos_nxt  (w_pitch_pos),
        .o_goal_nxt (w_pitch_goal),
        .o_write    (w_pitch_write)
    );

    // ---------------- result register ----------------
    logic                         r_valid;
    logic signed [ANGLE_BITS-1:0] r_yaw_now, r_pitch_now, r_yaw_goal, r_pitch_goal;
    logic                         r_moving, r_yaw_write, r_pitch_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_yaw_now     <= w_yaw_pos;
            r_pitch_now   <= w_pitch_pos;
            r_yaw_goal    <= w_yaw_goal;
            r_pitch_goal  <= w_pitch_goal;
            r_moving      <= (w_yaw_pos != w_yaw_goal) || (w_pitch_pos != w_pitch_goal);
            r_yaw_write   <= w_update && w_yaw_write;
            r_pitch_write <= w_update && w_pitch_write;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.yaw_now     = r_yaw_now;
    assign o_res.pitch_now   = r_pitch_now;
    assign o_res.yaw_goal    = r_yaw_goal;
    assign o_res.pitch_goal  = r_pitch_goal;
    assign o_res.moving      = r_moving;
    assign o_res.yaw_write   = r_yaw_write;
    assign o_res.pitch_write = r_pitch_write;

endmodule

// ===== sim/tslp_checker.sv =====
// Checker for the slew limiter: watches all three channels, predicts each result and compares.
`timescale 1ns / 1ps

module tslp_checker
    import tslp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tslp_cmd_if  i_cmd,
    tslp_res_if  i_res,
    tslp_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int AW         = ANGLE_BITS_DEF;
    localparam int MAX_PRINTS = 100;

    typedef logic signed [AW-1:0] t_angle;

    typedef struct packed {
        t_angle yaw_now;
        t_angle pitch_now;
        t_angle yaw_goal;
        t_angle pitch_goal;
        logic   moving;
        logic   yaw_write;
        logic   pitch_write;
    } t_pose_result;

    // Shadow registers
    t_angle               yaw_lo, yaw_hi, pitch_lo, pitch_hi;
    logic [STEP_BITS-1:0] step_amt, yaw_nudge_amt, pitch_nudge_amt;
    logic [TICK_BITS-1:0] tick_period;

    // Shadow state
    t_angle               yaw_cur, yaw_tgt, pitch_cur, pitch_tgt;
    logic [TICK_BITS-1:0] tick_count;

    t_pose_result expected_poses[$];
    int           fail_count  = 0;
    int           print_count = 0;

    assign o_fail_count = fail_count;

    function automatic t_angle limit_angle(input int v, input t_angle lo, input t_angle hi);
        if (v < int'(lo)) return lo;
        if (v > int'(hi)) return hi;
        return t_angle'(v);
    endfunction

    function automatic t_angle slew_toward(input t_angle cur, input t_angle goal,
                                           input int step);
        int c;
        c = int'(cur);
        if (c < int'(goal)) begin
            c = c + step;
            if (c > int'(goal)) c = int'(goal);
        end else if (c > int'(goal)) begin
            c = c - step;
            if (c < int'(goal)) c = int'(goal);
        end
        return t_angle'(c);
    endfunction

    task automatic reset_model();
        yaw_lo          = t_angle'(-(YAW_LIMIT_DEG << FRAC_BITS_DEF));
        yaw_hi          = t_angle'(YAW_LIMIT_DEG << FRAC_BITS_DEF);
        pitch_lo        = t_angle'(-(PITCH_LIMIT_DEG << FRAC_BITS_DEF));
        pitch_hi        = t_angle'(PITCH_LIMIT_DEG << FRAC_BITS_DEF);
        step_amt        = STEP_BITS'(1 << FRAC_BITS_DEF);
        yaw_nudge_amt   = STEP_BITS'(1 << FRAC_BITS_DEF);
        pitch_nudge_amt = STEP_BITS'(1 << FRAC_BITS_DEF);
        tick_period     = TICK_BITS'(INTERVAL_RST);
        yaw_cur         = '0;
        yaw_tgt         = '0;
        pitch_cur       = '0;
        pitch_tgt       = '0;
        tick_count      = '0;
        expected_poses.delete();
    endtask

    task automatic apply_register(input logic [ADDR_BITS-1:0] addr, input logic [15:0] data);
        case (addr)
            CFG_YAW_MIN:     yaw_lo          = t_angle'(data[AW-1:0]);
            CFG_YAW_MAX:     yaw_hi          = t_angle'(data[AW-1:0]);
            CFG_PITCH_MIN:   pitch_lo        = t_angle'(data[AW-1:0]);
            CFG_PITCH_MAX:   pitch_hi        = t_angle'(data[AW-1:0]);
            CFG_STEP_SIZE:   step_amt        = data[STEP_BITS-1:0];
            CFG_INTERVAL:    tick_period     = data[TICK_BITS-1:0];
            CFG_YAW_NUDGE:   yaw_nudge_amt   = data[STEP_BITS-1:0];
            CFG_PITCH_NUDGE: pitch_nudge_amt = data[STEP_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_request(input logic [OP_BITS-1:0] op, input t_angle yv,
                                   input t_angle pv);
        t_pose_result exp_pose;
        t_angle       yaw_prev, pitch_prev;
        int           next_count;
        yaw_prev   = yaw_cur;
        pitch_prev = pitch_cur;
        case (op)
            OP_TICK: begin
                next_count = int'(tick_count) + 1;
                if (next_count >= int'(tick_period)) begin
                    tick_count = '0;
                    yaw_cur    = slew_toward(yaw_cur, yaw_tgt, int'(step_amt));
                    pitch_cur  = slew_toward(pitch_cur, pitch_tgt, int'(step_amt));
                end else begin
                    tick_count = TICK_BITS'(next_count);
                end
            end
            OP_SET_YAW:   yaw_tgt = limit_angle(int'(yv), yaw_lo, yaw_hi);
            OP_SET_PITCH: pitch_tgt = limit_angle(int'(pv), pitch_lo, pitch_hi);
            OP_SET_POSE: begin
                yaw_tgt   = limit_angle(int'(yv), yaw_lo, yaw_hi);
                pitch_tgt = limit_angle(int'(pv), pitch_lo, pitch_hi);
            end
            OP_LEFT:  yaw_tgt = limit_angle(int'(yaw_tgt) - int'(yaw_nudge_amt), yaw_lo, yaw_hi);
            OP_RIGHT: yaw_tgt = limit_angle(int'(yaw_tgt) + int'(yaw_nudge_amt), yaw_lo, yaw_hi);
            OP_UP: begin
                pitch_tgt = limit_angle(int'(pitch_tgt) - int'(pitch_nudge_amt),
                                        pitch_lo, pitch_hi);
            end
            OP_DOWN: begin
                pitch_tgt = limit_angle(int'(pitch_tgt) + int'(pitch_nudge_amt),
                                        pitch_lo, pitch_hi);
            end
            OP_CENTER: begin
                yaw_tgt   = limit_angle(0, yaw_lo, yaw_hi);
                pitch_tgt = limit_angle(0, pitch_lo, pitch_hi);
            end
            default: ;  // unused codes leave everything alone
        endcase
        exp_pose.yaw_now     = yaw_cur;
        exp_pose.pitch_now   = pitch_cur;
        exp_pose.yaw_goal    = yaw_tgt;
        exp_pose.pitch_goal  = pitch_tgt;
        exp_pose.moving      = (yaw_cur != yaw_tgt) || (pitch_cur != pitch_tgt);
        exp_pose.yaw_write   = (yaw_cur != yaw_prev);
        exp_pose.pitch_write = (pitch_cur != pitch_prev);
        expected_poses.push_back(exp_pose);
    endtask

    task automatic report_mismatch(input string what, input t_pose_result got,
                                   input t_pose_result exp_pose);
        fail_count++;
        if (print_count < MAX_PRINTS) begin
            print_count++;
            $display("%0t mismatch: %s got yaw %0d/%0d pitch %0d/%0d mv %0b wr %0b%0b, exp yaw %0d/%0d pitch %0d/%0d mv %0b wr %0b%0b",
                     $realtime, what, got.yaw_now, got.yaw_goal, got.pitch_now,
                     got.pitch_goal, got.moving, got.yaw_write, got.pitch_write,
                     exp_pose.yaw_now, exp_pose.yaw_goal, exp_pose.pitch_now,
                     exp_pose.pitch_goal, exp_pose.moving, exp_pose.yaw_write,
                     exp_pose.pitch_write);
        end
    endtask

    task automatic check_result();
        t_pose_result got, exp_pose;
        got.yaw_now     = i_res.yaw_now;
        got.pitch_now   = i_res.pitch_now;
        got.yaw_goal    = i_res.yaw_goal;
        got.pitch_goal  = i_res.pitch_goal;
        got.moving      = i_res.moving;
        got.yaw_write   = i_res.yaw_write;
        got.pitch_write = i_res.pitch_write;
        if (expected_poses.size() == 0) begin
            report_mismatch("unexpected result", got, got);
        end else begin
            exp_pose = expected_poses.pop_front();
            if (got !== exp_pose) report_mismatch("wrong field", got, exp_pose);
        end
    endtask

    // Registers first, then the result leaving, then the request entering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg.valid && i_cfg.ready) apply_register(i_cfg.addr, i_cfg.data);
            if (i_res.valid && i_res.ready) check_result();
            if (i_cmd.valid && i_cmd.ready) begin
                predict_request(i_cmd.operation, i_cmd.yaw_value, i_cmd.pitch_value);
            end
        end
        o_pending = expected_poses.size();
    end

endmodule

// ===== sim/tb_two_axis_slew_limited_positioner_top.sv =====
// Testbench top: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_two_axis_slew_limited_positioner_top;
    import tslp_pkg::*;

    localparam int AW           = ANGLE_BITS_DEF;
    localparam int HOLD_CYCLES  = 60;     // long receiver hold-off
    localparam int PHASE_ITEMS  = 115;    // random requests per phase
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE       = 4;      // cycles past the last result
    localparam logic [OP_BITS-1:0] OP_FIRST_UNUSED = OP_BITS'(OP_CENTER + 1);
    localparam logic [OP_BITS-1:0] OP_LAST_UNUSED  = '1;

    typedef logic signed [AW-1:0] t_angle;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_asks;
    int   fail_count;
    int   pending;

    tslp_cmd_if cmd_if ();
    tslp_res_if res_if ();
    tslp_cfg_if cfg_if ();

    two_axis_slew_limited_positioner_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    tslp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Safety net: the slowest run is far below this.
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side. Random back-pressure, plus a long hold-off whenever the
    // stimulus asks for one; the hold-off is counted here so the sender keeps
    // offering requests and the single result register fills up.
    initial begin
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_angle rand_angle();
        return t_angle'($urandom);
    endfunction

    // Offer one request; random idle cycles first. Returns at the falling edge
    // after acceptance with valid still high, so back-to-back requests never
    // drop valid in between.
    task automatic send_request(input logic [OP_BITS-1:0] op, input t_angle yv,
                                input t_angle pv);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.operation   <= op;
        cmd_if.yaw_value   <= yv;
        cmd_if.pitch_value <= pv;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and let every outstanding result drain.
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // One write, then valid drops again to idle the register channel.
    task automatic cfg_write(input t_cfg_addr addr, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= addr;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly ticks and target changes; a few unused codes mixed in.
    task automatic send_random_request();
        int                 r;
        logic [OP_BITS-1:0] op;
        r = $urandom_range(99);
        if      (r < 40) op = OP_TICK;
        else if (r < 50) op = OP_SET_YAW;
        else if (r < 58) op = OP_SET_PITCH;
        else if (r < 66) op = OP_SET_POSE;
        else if (r < 72) op = OP_LEFT;
        else if (r < 78) op = OP_RIGHT;
        else if (r < 84) op = OP_UP;
        else if (r < 90) op = OP_DOWN;
        else if (r < 95) op = OP_CENTER;
        else             op = OP_BITS'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        send_request(op, rand_angle(), rand_angle());
    endtask

    // Full register set for one phase. Phase 1 pins the extremes, phase 3
    // crosses the yaw limits and uses the longest update interval.
    task automatic program_phase(input int p);
        t_angle               ylo, yhi, plo, phi, swap;
        logic [STEP_BITS-1:0] step, ynudge, pnudge;
        logic [TICK_BITS-1:0] period;
        ylo = rand_angle();
        yhi = rand_angle();
        plo = rand_angle();
        phi = rand_angle();
        if (ylo > yhi) begin
            swap = ylo; ylo = yhi; yhi = swap;
        end
        if (plo > phi) begin
            swap = plo; plo = phi; phi = swap;
        end
        step   = STEP_BITS'($urandom_range(64, 1));
        period = TICK_BITS'($urandom_range(4, 0));
        ynudge = STEP_BITS'($urandom_range(300, 0));
        pnudge = STEP_BITS'($urandom_range(300, 0));
        if (p == 1) begin
            ylo    = {1'b1, {(AW-1){1'b0}}};
            yhi    = {1'b0, {(AW-1){1'b1}}};
            plo    = ylo;
            phi    = yhi;
            step   = '1;
            period = 16'd1;
            ynudge = '1;
            pnudge = '1;
        end
        if (p == 3) begin
            swap   = ylo; ylo = yhi; yhi = swap;
            period = '1;
        end
        cfg_write(CFG_YAW_MIN,     16'(ylo));
        cfg_write(CFG_YAW_MAX,     16'(yhi));
        cfg_write(CFG_PITCH_MIN,   16'(plo));
        cfg_write(CFG_PITCH_MAX,   16'(phi));
        cfg_write(CFG_STEP_SIZE,   16'(step));
        cfg_write(CFG_INTERVAL,    period);
        cfg_write(CFG_YAW_NUDGE,   16'(ynudge));
        cfg_write(CFG_PITCH_NUDGE, 16'(pnudge));
    endtask

    initial begin
        t_angle ang_min;
        t_angle ang_max;
        ang_min = {1'b1, {(AW-1){1'b0}}};
        ang_max = {1'b0, {(AW-1){1'b1}}};

        // Every input known from time zero.
        i_rst_n            = 1'b0;
        send_idle_pct      = 17;
        recv_idle_pct      = 87;
        hold_asks          = 0;
        cmd_if.valid       = 1'b0;
        cmd_if.operation   = OP_TICK;
        cmd_if.yaw_value   = '0;
        cmd_if.pitch_value = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.addr        = CFG_YAW_MIN;
        cfg_if.data        = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset registers: out-of-range targets clamp, every
        // nudge direction, center, unused codes leave state alone.
        send_request(OP_SET_POSE, ang_max, ang_min);
        send_request(OP_TICK, ang_min, ang_max);
        send_request(OP_LEFT, '0, '0);
        send_request(OP_UP, '0, '0);
        send_request(OP_RIGHT, '0, '0);
        send_request(OP_DOWN, '0, '0);
        send_request(OP_CENTER, ang_max, ang_max);
        send_request(OP_FIRST_UNUSED, ang_min, ang_min);
        send_request(OP_LAST_UNUSED, ang_max, ang_min);
        send_request(OP_SET_YAW, ang_min, ang_max);
        send_request(OP_SET_PITCH, ang_min, ang_max);

        // Zero interval updates on every tick, but a zero step never moves.
        wait_idle();
        cfg_write(CFG_INTERVAL, 16'd0);
        cfg_write(CFG_STEP_SIZE, 16'd0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);

        // Largest step lands exactly on the target, then stays.
        wait_idle();
        cfg_write(CFG_STEP_SIZE, 16'h07FF);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);

        // Crossed yaw limits with the largest nudge: below min gives min,
        // everything else gives max.
        wait_idle();
        cfg_write(CFG_YAW_MIN, 16'sd100);
        cfg_write(CFG_YAW_MAX, -16'sd100);
        cfg_write(CFG_YAW_NUDGE, 16'h07FF);
        send_request(OP_SET_YAW, ang_min, '0);
        send_request(OP_SET_YAW, '0, '0);
        send_request(OP_RIGHT, '0, '0);
        send_request(OP_LEFT, '0, '0);
        send_request(OP_CENTER, '0, '0);
        send_request(OP_TICK, '0, '0);

        // Random phases: sender-light/receiver-heavy idling, then swapped,
        // then none. Phase 3 pauses mid-way until every result is back;
        // phase 4 triggers the long receiver hold-off under full offer.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct = 17;
                recv_idle_pct = 87;
            end else if (p < 4) begin
                send_idle_pct = 87;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            program_phase(p);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == PHASE_ITEMS / 2) wait_idle();
                if (p == 4 && i == 30) hold_asks <= hold_asks + 1;
                send_random_request();
            end
        end

        // Drain and give the verdict.
        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
